/* sv/stid_pkg.sv */
// Package for the sorted table insert/delete core.
// Holds field widths, status and kind codes and the cell command type.
// Depends on nothing; every other file but stid_search uses it by scoped names.
package stid_pkg;

	// Default table depth
	localparam int DEPTH_DEF = 16;

	// Fixed field widths
	localparam int KEY_W  = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;

	// Item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	// Action broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [KEY_W-1:0] key;
	} cell_cmd_t;

endpackage

/* sv/stid_cell.sv */
// One slot of the sorted table: holds an entry, compares it with the key.
// Depends on stid_pkg for the command type and key width.
// Shifts in from the left neighbour on insert, from the right on delete.
module stid_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic                               clk,
	input  stid_pkg::cell_cmd_t                cmd,
	input  logic [CW-1:0]                      pos,
	input  logic signed [stid_pkg::KEY_W-1:0]  left_entry,
	input  logic signed [stid_pkg::KEY_W-1:0]  right_entry,
	output logic signed [stid_pkg::KEY_W-1:0]  entry,
	output logic                               lt,
	output logic                               eq
);

	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic signed [stid_pkg::KEY_W-1:0] entry_q;
	logic                              lt_q;
	logic                              eq_q;

	// Register compare flags against the broadcast key every cycle
	always_ff @(posedge clk) begin
		lt_q <= cmd.key < entry_q;
		eq_q <= cmd.key == entry_q;
	end

	// Place, shift up or shift down as the command says; hold otherwise
	always_ff @(posedge clk) begin
		case (cmd.op)
			stid_pkg::OP_INSERT: begin
				if (MY_IDX == pos) begin
					entry_q <= cmd.key;
				end else if (MY_IDX > pos) begin
					entry_q <= left_entry;
				end
			end
			stid_pkg::OP_DELETE: begin
				if (MY_IDX >= pos) begin
					entry_q <= right_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

/* sv/stid_search.sv */
// Binary search sequencer over the registered compare flags of the cells.
// Uses nothing from stid_pkg; one probe per cycle.
// Reproduces mid = (lo + hi) / 2 exactly, so duplicates resolve alike.
module stid_search #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(DEPTH+1)-1:0]       count,
	input  logic [DEPTH-1:0]                 lt_flags,
	input  logic [DEPTH-1:0]                 eq_flags,
	output logic                             done,
	output logic                             hit,
	output logic [$clog2(DEPTH+1)-1:0]       pos
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int MW = AW + 2;
	localparam logic signed [SW-1:0] ONE_S = SW'(1);

	logic                 busy_q;
	logic                 done_q;
	logic                 hit_q;
	logic [CW-1:0]        pos_q;
	logic signed [SW-1:0] lo_q;
	logic signed [SW-1:0] hi_q;

	logic [MW-1:0]        sum;
	logic [AW-1:0]        mid;
	logic signed [SW-1:0] mid_s;
	logic signed [SW-1:0] pos_s;

	// Midpoint of the live window; both bounds are non-negative here
	always_comb begin
		sum   = MW'(lo_q[CW-1:0]) + MW'(hi_q[CW-1:0]);
		mid   = sum[AW:1];
		mid_s = $signed(SW'(mid));
		pos_s = hi_q + ONE_S;
	end

	// Narrow the window one probe per cycle until hit or empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			pos_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				lo_q   <= '0;
				hi_q   <= $signed({1'b0, count}) - ONE_S;
			end else if (busy_q) begin
				if (lo_q > hi_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= 1'b0;
					pos_q  <= pos_s[CW-1:0];
				end else if (eq_flags[mid]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= 1'b1;
					pos_q  <= CW'(mid);
				end else if (lt_flags[mid]) begin
					done_q <= 1'b0;
					hi_q   <= mid_s - ONE_S;
				end else begin
					done_q <= 1'b0;
					lo_q   <= mid_s + ONE_S;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign hit  = hit_q;
	assign pos  = pos_q;

endmodule

/* sv/sorted_table_insert_delete_core.sv */
// Sorted table core: a row of compare-and-shift cells plus a search sequencer.
// An item passes the compare, search and apply states before its result is
// registered; the search makes one probe per cycle over the cell flags.
// Throughput: one item at a time; the next input is taken once the result
// is in the output register. Reset clears the count and control; entries
// keep whatever they held and are only read below the count.
module sorted_table_insert_delete_core #(
	parameter int DEPTH = stid_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic signed [stid_pkg::KEY_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [stid_pkg::POS_W-1:0]         position,
	output logic                               found,
	output logic [stid_pkg::POS_W-1:0]         new_count,
	output logic [stid_pkg::STAT_W-1:0]        status
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SRCH,
		S_APPLY
	} state_t;

	state_t                            state_q;
	logic                              kind_q;
	logic signed [stid_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]                     count_q;
	logic                              out_valid_q;
	logic [stid_pkg::POS_W-1:0]        position_q;
	logic                              found_q;
	logic [stid_pkg::POS_W-1:0]        new_count_q;
	logic [stid_pkg::STAT_W-1:0]       status_q;

	stid_pkg::cell_cmd_t               cmd;
	logic [DEPTH-1:0]                  lt_flags;
	logic [DEPTH-1:0]                  eq_flags;
	logic signed [stid_pkg::KEY_W-1:0] entry_v [DEPTH];

	logic                              srch_start;
	logic                              srch_done;
	logic                              srch_hit;
	logic [CW-1:0]                     srch_pos;

	logic                              apply_fire;
	logic                              full;
	logic [CW-1:0]                     count_next;
	logic [stid_pkg::STAT_W-1:0]       status_next;
	stid_pkg::cell_op_t                op_next;
	logic [31:0]                       pos_ext;
	logic [31:0]                       cnt_ext;

	// Decide the table action once the search has settled
	always_comb begin
		apply_fire  = (state_q == S_APPLY) && (!out_valid_q || out_ready);
		full        = count_q == CW'(DEPTH);
		count_next  = count_q;
		status_next = stid_pkg::ST_DONE;
		op_next     = stid_pkg::OP_HOLD;
		if (kind_q == stid_pkg::KIND_INSERT) begin
			if (full) begin
				status_next = stid_pkg::ST_FULL;
			end else begin
				op_next    = stid_pkg::OP_INSERT;
				count_next = count_q + CW'(1);
			end
		end else begin
			if (!srch_hit) begin
				status_next = stid_pkg::ST_NOTFOUND;
			end else begin
				op_next    = stid_pkg::OP_DELETE;
				count_next = count_q - CW'(1);
			end
		end
		pos_ext = 32'(srch_pos);
		cnt_ext = 32'(count_next);
	end

	// Broadcast key every cycle; act only on the applying cycle
	always_comb begin
		cmd.key    = key_q;
		cmd.op     = apply_fire ? op_next : stid_pkg::OP_HOLD;
		srch_start = state_q == S_CMP;
		in_ready   = state_q == S_IDLE;
	end

	// Row of cells, each linked to both neighbours
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [stid_pkg::KEY_W-1:0] left_e;
		logic signed [stid_pkg::KEY_W-1:0] right_e;
		if (i == 0) begin : g_first
			assign left_e = key_q;
		end else begin : g_mid_l
			assign left_e = entry_v[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_e = entry_v[i];
		end else begin : g_mid_r
			assign right_e = entry_v[i+1];
		end
		stid_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.pos         (srch_pos),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (entry_v[i]),
			.lt          (lt_flags[i]),
			.eq          (eq_flags[i])
		);
	end

	stid_search #(
		.DEPTH (DEPTH)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (srch_start),
		.count    (count_q),
		.lt_flags (lt_flags),
		.eq_flags (eq_flags),
		.done     (srch_done),
		.hit      (srch_hit),
		.pos      (srch_pos)
	);

	// Sequence the item and hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			key_q       <= '0;
			position_q  <= '0;
			found_q     <= 1'b0;
			new_count_q <= '0;
			status_q    <= stid_pkg::ST_DONE;
		end else begin
			if (out_valid_q && out_ready && !apply_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						key_q   <= value;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (srch_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (apply_fire) begin
						count_q     <= count_next;
						out_valid_q <= 1'b1;
						position_q  <= pos_ext[stid_pkg::POS_W-1:0];
						found_q     <= srch_hit;
						new_count_q <= cnt_ext[stid_pkg::POS_W-1:0];
						status_q    <= status_next;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign found     = found_q;
	assign new_count = new_count_q;
	assign status    = status_q;

	// The count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("table count above depth");

	// A rejected insert leaves a full table
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == stid_pkg::ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("insert rejected while table not full");

	// A missed delete never reports a match
	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == stid_pkg::ST_NOTFOUND) |-> !found_q)
		else $error("not-found status with match flag set");

	// Search completes only while the sequencer waits for it
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> state_q == S_SRCH)
		else $error("search finished outside search state");

endmodule

/* test/sorted_table_insert_delete_core_tb.sv */
// Self-checking testbench for sorted_table_insert_delete_core.
// Predicts every result with a shadow sorted table and checks each result transfer.
// Depends on stid_pkg and the core; needs no other files.
module sorted_table_insert_delete_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH    = stid_pkg::DEPTH_DEF;
	localparam int RAND_ITEMS   = 1250;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;
	localparam int LONG_HOLD_AT = 600;
	localparam int LONG_HOLD    = 200;
	localparam int CALM_TAIL    = 150;

	typedef struct packed {
		logic                              drain;
		logic                              kind;
		logic signed [stid_pkg::KEY_W-1:0] value;
	} table_op_t;

	typedef struct packed {
		logic [stid_pkg::POS_W-1:0]  position;
		logic                        found;
		logic [stid_pkg::POS_W-1:0]  new_count;
		logic [stid_pkg::STAT_W-1:0] status;
	} table_result_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              in_valid  = 1'b0;
	logic                              kind      = stid_pkg::KIND_INSERT;
	logic signed [stid_pkg::KEY_W-1:0] value     = '0;
	logic                              out_ready = 1'b0;
	logic                              in_ready;
	logic                              out_valid;
	logic [stid_pkg::POS_W-1:0]        position;
	logic                              found;
	logic [stid_pkg::POS_W-1:0]        new_count;
	logic [stid_pkg::STAT_W-1:0]       status;

	// Shadow of the table contents and the count
	logic signed [stid_pkg::KEY_W-1:0] shadow_tbl [TBL_DEPTH];
	int                                shadow_cnt = 0;

	table_op_t     pending_q [$];
	table_result_t result_q  [$];

	int total_items    = 0;
	int sent_cnt       = 0;
	int in_xfers       = 0;
	int out_xfers      = 0;
	int err_cnt        = 0;
	int tx_gap         = 0;
	int rx_gap         = 0;
	int long_hold_left = 0;
	bit long_hold_done = 1'b0;

	int n_insert = 0, n_delete = 0, n_full = 0, n_missing = 0, n_hits = 0, peak_cnt = 0;

	sorted_table_insert_delete_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position),
		.found     (found),
		.new_count (new_count),
		.status    (status)
	);

	// Clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one insert or delete to the shadow table and return its result
	function automatic table_result_t sorted_table_apply(input logic op_kind,
			input logic signed [stid_pkg::KEY_W-1:0] key);
		table_result_t res;
		int lo, hi, mid, pos;
		bit hit;
		lo  = 0;
		hi  = shadow_cnt - 1;
		hit = 1'b0;
		pos = 0;
		// binary search; with duplicates the first equal probe wins
		while (lo <= hi && !hit) begin
			mid = (lo + hi) / 2;
			if (key == shadow_tbl[mid]) begin
				hit = 1'b1;
				pos = mid;
			end else if (key < shadow_tbl[mid]) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		if (!hit)
			pos = hi + 1;
		res.status = stid_pkg::ST_DONE;
		if (op_kind == stid_pkg::KIND_INSERT) begin
			if (shadow_cnt >= TBL_DEPTH) begin
				res.status = stid_pkg::ST_FULL;
			end else begin
				for (int i = shadow_cnt; i > pos; i--)
					shadow_tbl[i] = shadow_tbl[i-1];
				shadow_tbl[pos] = key;
				shadow_cnt++;
			end
		end else begin
			if (!hit) begin
				res.status = stid_pkg::ST_NOTFOUND;
			end else begin
				for (int i = pos; i + 1 < shadow_cnt; i++)
					shadow_tbl[i] = shadow_tbl[i+1];
				shadow_cnt--;
			end
		end
		res.position  = stid_pkg::POS_W'(pos);
		res.found     = hit;
		res.new_count = stid_pkg::POS_W'(shadow_cnt);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("MISMATCH at result %0d: %s got %0d expected %0d",
				out_xfers, what, got, want);
	endtask

	// Driver: present queued items at the falling edge, hold until transferred
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_xfers != sent_cnt) begin
			// hold the offered item unchanged
		end else if (tx_gap > 0) begin
			tx_gap--;
			in_valid <= 1'b0;
		end else if (sent_cnt < total_items - CALM_TAIL && (sent_cnt / 100) % 4 != 3 &&
				long_hold_left == 0 && $urandom_range(0, 9) == 0) begin
			tx_gap = $urandom_range(0, 14);
			in_valid <= 1'b0;
		end else if (pending_q.size() != 0 && (!pending_q[0].drain || result_q.size() == 0)) begin
			kind     <= pending_q[0].kind;
			value    <= pending_q[0].value;
			in_valid <= 1'b1;
			sent_cnt++;
			void'(pending_q.pop_front());
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (!long_hold_done && in_xfers >= LONG_HOLD_AT) begin
			long_hold_left = LONG_HOLD;
			long_hold_done = 1'b1;
		end
		if (long_hold_left > 0) begin
			long_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if (out_xfers < total_items - CALM_TAIL && (out_xfers / 120) % 4 != 2 &&
				$urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: check result transfers, then predict for input transfers
	always @(posedge clk) begin : monitor
		table_result_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{position: position, found: found, new_count: new_count,
					status: status};
				if (result_q.size() == 0) begin
					report_mismatch("result with none pending, position",
						int'(got.position), 0);
				end else begin
					want = result_q.pop_front();
					if (got.position !== want.position)
						report_mismatch("position", int'(got.position),
							int'(want.position));
					if (got.found !== want.found)
						report_mismatch("found", int'(got.found), int'(want.found));
					if (got.new_count !== want.new_count)
						report_mismatch("new_count", int'(got.new_count),
							int'(want.new_count));
					if (got.status !== want.status)
						report_mismatch("status", int'(got.status), int'(want.status));
				end
				out_xfers++;
			end
			if (in_valid && in_ready) begin
				want = sorted_table_apply(kind, value);
				result_q.push_back(want);
				in_xfers++;
				if (kind == stid_pkg::KIND_INSERT) n_insert++; else n_delete++;
				if (want.status == stid_pkg::ST_FULL) n_full++;
				if (want.status == stid_pkg::ST_NOTFOUND) n_missing++;
				if (want.found) n_hits++;
				if (shadow_cnt > peak_cnt) peak_cnt = shadow_cnt;
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TIMEOUT: no transfer for %0d cycles", QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int                                ins_pct;
		logic                              k;
		logic signed [stid_pkg::KEY_W-1:0] v;

		// empty table: delete misses at position 0
		pending_q.push_back('{1'b0, stid_pkg::KIND_DELETE, 32'sd0});
		// extremes and neighbours of zero
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sd0});
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sh7FFF_FFFF});
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sh8000_0000});
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, -32'sd1});
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sd1});
		// duplicates kept, then one copy removed
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sd0});
		pending_q.push_back('{1'b0, stid_pkg::KIND_DELETE, 32'sd0});
		// delete of an absent value in the middle
		pending_q.push_back('{1'b0, stid_pkg::KIND_DELETE, 32'sd5});
		// fill up, with repeats of the largest value
		for (int i = 0; i < 11; i++)
			pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT,
				(i % 3 == 0) ? 32'sh7FFF_FFFF : 32'(i * 7 - 30)});
		// full table rejects inserts at both ends
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sh7FFF_FFFF});
		pending_q.push_back('{1'b0, stid_pkg::KIND_INSERT, 32'sh8000_0000});
		pending_q.push_back('{1'b0, stid_pkg::KIND_DELETE, 32'sh7FFF_FFFF});
		pending_q.push_back('{1'b0, stid_pkg::KIND_DELETE, 32'sh8000_0000});

		// random phases that lean towards insert or delete so the count sweeps
		ins_pct = 80;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 50 == 0)
				ins_pct = ((i / 50) % 2 == 0) ? 80 : 25;
			k = ($urandom_range(1, 100) <= ins_pct) ? stid_pkg::KIND_INSERT :
				stid_pkg::KIND_DELETE;
			case ($urandom_range(0, 9))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7FFF_FFFF;
				2: v = -32'sd1;
				3: v = 32'sd0;
				4: v = 32'sd77;
				5, 6: v = 32'($urandom_range(0, 40)) - 32'sd20;
				default: v = $urandom;
			endcase
			pending_q.push_back('{(i % 400 == 0), k, v});
		end
		total_items = pending_q.size();

		// hold reset, then release it at a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait until every item is transferred and every result is back
		while (pending_q.size() != 0 || in_xfers != sent_cnt || result_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (result_q.size() != 0)
			report_mismatch("results still outstanding", result_q.size(), 0);

		$display("Covered %0d inserts and %0d deletes, table peak %0d of %0d entries",
			n_insert, n_delete, peak_cnt, TBL_DEPTH);
		$display("Saw %0d full rejects, %0d missed deletes, %0d matches, %0d mismatches",
			n_full, n_missing, n_hits, err_cnt);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
